FILE: hw/rtl/i2creg_pkg.sv
// ----------------------------------------------------------------------------
// I2C target register file package
// Shared constants, bus event codes and request payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2creg_pkg;

  // Default number of register bytes.
  localparam int DefaultRegDepth = 256;

  // Width of the used size register and of the register pointer.
  localparam int SizeW = 9;

  // Configuration bus widths.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // Configuration register indexes.
  localparam logic CfgIdxUsedSize = 1'b0;

  // Byte sent when no valid pointer is available.
  localparam logic [7:0] TxFillByte = 8'hFF;

  // Bus and local event codes.
  localparam logic [2:0] OpAddrMatch  = 3'd0;
  localparam logic [2:0] OpRxByte     = 3'd1;
  localparam logic [2:0] OpTxRequest  = 3'd2;
  localparam logic [2:0] OpStop       = 3'd3;
  localparam logic [2:0] OpSetPerm    = 3'd4;
  localparam logic [2:0] OpLocalWrite = 3'd5;
  localparam logic [2:0] OpLocalRead  = 3'd6;

  // Bus transfer phases.
  localparam logic [1:0] PhaseIdle = 2'd0;
  localparam logic [1:0] PhaseRx   = 2'd1;
  localparam logic [1:0] PhaseTx   = 2'd2;

  // Input request payload.
  typedef struct packed {
    logic [2:0] op;
    logic       dir_read;
    logic [7:0] data_in;
    logic [7:0] byte_addr;
    logic       writable;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       write_done;
    logic [7:0] local_data;
  } out_item_t;

  // One register entry: write permission bit and stored byte.
  typedef struct packed {
    logic       writable;
    logic [7:0] value;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2creg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2creg_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/i2creg_cfg.sv
// ----------------------------------------------------------------------------
// I2C target register file configuration port
// APB-style access to the used size register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2creg_cfg
  import i2creg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready,
  output logic      [SizeW-1:0]    used_size_o
);

  logic [SizeW-1:0] used_size_q;
  logic [SizeW-1:0] used_size_d;
  logic             sel_used_size;

  // Register index sits in the word address bit.
  assign sel_used_size = (paddr[2] == CfgIdxUsedSize);

  // Write on the access phase of a write transfer.
  always_comb begin
    used_size_d = used_size_q;
    if (psel && penable && pwrite && sel_used_size) begin
      used_size_d = pwdata[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= '0;
    end else begin
      used_size_q <= used_size_d;
    end
  end

  // Read data and a port that never waits.
  assign prdata      = sel_used_size ? CfgDataW'(used_size_q) : '0;
  assign pready      = 1'b1;
  assign used_size_o = used_size_q;

endmodule

`default_nettype wire

FILE: hw/rtl/i2creg_core.sv
// ----------------------------------------------------------------------------
// I2C target register file core
// Bus phase tracking, pointer handling and read-modify-write of the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2creg_core
  import i2creg_pkg::*;
#(
  parameter int RegDepth = DefaultRegDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SizeW-1:0] used_size_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o
);

  localparam int AddrW = $clog2(RegDepth);
  localparam logic [SizeW-1:0] DepthW = SizeW'(RegDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(RegDepth - 1);

  // Sequencer states.
  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [1:0]       phase_q, phase_d;
  logic [SizeW-1:0] ptr_q, ptr_d;
  logic             ptr_set_q, ptr_set_d;
  in_item_t         item_q;
  logic [AddrW-1:0] addr_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic             accept;
  logic             exec_go;
  logic [AddrW-1:0] rd_addr;
  entry_t           rd_entry;
  logic             upd_en;
  entry_t           upd_entry;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [SizeW-1:0] size;
  logic             ptr_in_range;
  logic             local_in_range;

  // Requests are taken only between items and after the clearing pass.
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign exec_go    = (state_q == StExec) && !(out_valid_q && out_stall_i);

  // Bus transfers address the store by pointer, local requests by byte address.
  always_comb begin
    if (in_item_i.op == OpRxByte || in_item_i.op == OpTxRequest) begin
      rd_addr = ptr_q[AddrW-1:0];
    end else begin
      rd_addr = in_item_i.byte_addr[AddrW-1:0];
    end
  end

  // Write port: zeroes during the clearing pass, updates afterwards.
  assign ram_we    = (state_q == StClear) || (exec_go && upd_en);
  assign ram_waddr = (state_q == StClear) ? clr_cnt_q : addr_q;
  assign ram_wdata = (state_q == StClear) ? entry_t'('0) : upd_entry;

  i2creg_ram #(
    .Width($bits(entry_t)),
    .Depth(RegDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rd_entry)
  );

  // Range checks: the pointer against the effective size, local addresses against the store depth.
  assign size           = (used_size_i > DepthW) ? DepthW : used_size_i;
  assign ptr_in_range   = (ptr_q < size);
  assign local_in_range = ({1'b0, item_q.byte_addr} < DepthW);

  // Execute one request against the entry read when the request was accepted.
  always_comb begin
    phase_d    = phase_q;
    ptr_d      = ptr_q;
    ptr_set_d  = ptr_set_q;
    upd_en     = 1'b0;
    upd_entry  = rd_entry;
    out_item_d = '0;
    case (item_q.op)
      OpAddrMatch: begin
        if (phase_q == PhaseIdle || (phase_q == PhaseRx && item_q.dir_read)) begin
          if (item_q.dir_read) begin
            phase_d = PhaseTx;
          end else begin
            phase_d   = PhaseRx;
            ptr_set_d = 1'b0;
          end
        end
      end
      OpRxByte: begin
        if (phase_q == PhaseRx) begin
          if (!ptr_set_q) begin
            ptr_d     = SizeW'(item_q.data_in);
            ptr_set_d = 1'b1;
          end else if (ptr_in_range) begin
            if (rd_entry.writable) begin
              upd_en          = 1'b1;
              upd_entry.value = item_q.data_in;
            end
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      OpTxRequest: begin
        if (phase_q == PhaseTx) begin
          out_item_d.tx_valid = 1'b1;
          if (ptr_set_q && ptr_in_range) begin
            out_item_d.tx_data = rd_entry.value;
            ptr_d              = ptr_q + 1'b1;
          end else begin
            out_item_d.tx_data = TxFillByte;
          end
        end
      end
      OpStop: begin
        if (phase_q != PhaseIdle) begin
          out_item_d.write_done = (phase_q == PhaseRx);
          phase_d               = PhaseIdle;
        end
      end
      OpSetPerm: begin
        if (local_in_range) begin
          upd_en             = 1'b1;
          upd_entry.writable = item_q.writable;
        end
      end
      OpLocalWrite: begin
        if (local_in_range) begin
          upd_en          = 1'b1;
          upd_entry.value = item_q.data_in;
        end
      end
      OpLocalRead: begin
        if (local_in_range) begin
          out_item_d.local_data = rd_entry.value;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and clearing counter.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      StClear: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: loaded on execution, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (exec_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      phase_q     <= PhaseIdle;
      ptr_q       <= '0;
      ptr_set_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        phase_q   <= phase_d;
        ptr_q     <= ptr_d;
        ptr_set_q <= ptr_set_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      addr_q <= rd_addr;
    end
    if (exec_go) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_target_register_file_top.sv
// ----------------------------------------------------------------------------
// I2C target register file
// Byte register store served to an I2C bus master and a local port.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries one bus event (address match, received byte,
// transmit request, stop) or one local access (permission set, local write,
// local read). Every request yields exactly one result on the output channel.
// A request is accepted when in_valid_i is high and in_stall_o is low; a
// result is taken when out_valid_o is high and out_stall_i is low.
// Each request is first read from the synchronous RAM, which fetches the
// addressed store entry, and then executed, which updates the entry and
// loads the output register; a new request is accepted only after the
// previous one has executed. The result is held in the output register.
// The output register lets the next request be accepted while a result still
// waits; when the receiver stalls, the following request is held in its
// execute state until the output register frees up.
// After reset a clearing pass zeroes every byte and every write permission;
// in_stall_o stays high during it. The configuration port is usable at all
// times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_register_file_top
  import i2creg_pkg::*;
#(
  parameter int RegDepth = DefaultRegDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o
);

  logic [SizeW-1:0] used_size;

  // Configuration registers.
  i2creg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .used_size_o(used_size)
  );

  // Request processing around the register store.
  i2creg_core #(
    .RegDepth(RegDepth)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .used_size_i(used_size),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: sim/i2c_target_register_file_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target register file testbench
// Drives bus events and local accesses into the register file, predicts each
// response from a shadow copy of the pointer, phase, store and write map, and
// checks every response in order. Runs a directed sequence, then random
// transfers under several used sizes and idle and stall patterns.
// ----------------------------------------------------------------------------

module i2c_target_register_file_top_tb;
  import i2creg_pkg::*;

  localparam int StoreDepth = DefaultRegDepth;
  localparam int ReqW = $bits(in_item_t);
  localparam logic [2:0] OpUnused = 3'd7;
  localparam logic [CfgAddrW-1:0] UsedSizeAddr = CfgAddrW'(4 * int'(CfgIdxUsedSize));
  localparam int RequestsPerPhase = 150;
  localparam int NumPhases = 6;
  localparam int MaxReported = 10;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Stimulus and expected responses.
  in_item_t request_queue[$];
  out_item_t pending_responses[$];
  int generated_count = 0;
  int mismatch_count = 0;
  idle_mode_e idle_mode = IdleNone;

  // Captured response, checked on the falling edge.
  logic response_taken = 1'b0;
  out_item_t response_item = '0;

  // Shadow copy of the block state.
  logic [7:0] shadow_bytes [StoreDepth];
  logic shadow_writable [StoreDepth];
  logic [1:0] shadow_phase;
  logic [8:0] shadow_ptr;
  logic shadow_ptr_valid;
  logic [8:0] shadow_size;

  i2c_target_register_file_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sizes above the store depth act as the full store.
  function automatic int active_span();
    return (int'(shadow_size) > StoreDepth) ? StoreDepth : int'(shadow_size);
  endfunction

  // Applies one request to the shadow state and returns the response it causes.
  function automatic out_item_t predict_register_file_response(in_item_t req);
    out_item_t rsp;
    int span;
    rsp = '0;
    span = active_span();
    case (req.op)
      OpAddrMatch: begin
        // A repeated start to a read is taken while receiving; others are ignored when busy.
        if (shadow_phase == PhaseIdle || (shadow_phase == PhaseRx && req.dir_read)) begin
          if (req.dir_read) begin
            shadow_phase = PhaseTx;
          end else begin
            shadow_phase = PhaseRx;
            shadow_ptr_valid = 1'b0;
          end
        end
      end
      OpRxByte: begin
        if (shadow_phase == PhaseRx) begin
          if (!shadow_ptr_valid) begin
            shadow_ptr = {1'b0, req.data_in};
            shadow_ptr_valid = 1'b1;
          end else if (int'(shadow_ptr) < span) begin
            if (shadow_writable[shadow_ptr[7:0]]) begin
              shadow_bytes[shadow_ptr[7:0]] = req.data_in;
            end
            shadow_ptr = shadow_ptr + 9'd1;
          end
        end
      end
      OpTxRequest: begin
        if (shadow_phase == PhaseTx) begin
          rsp.tx_valid = 1'b1;
          if (shadow_ptr_valid && int'(shadow_ptr) < span) begin
            rsp.tx_data = shadow_bytes[shadow_ptr[7:0]];
            shadow_ptr = shadow_ptr + 9'd1;
          end else begin
            rsp.tx_data = TxFillByte;
          end
        end
      end
      OpStop: begin
        if (shadow_phase != PhaseIdle) begin
          rsp.write_done = (shadow_phase == PhaseRx);
          shadow_phase = PhaseIdle;
        end
      end
      OpSetPerm: shadow_writable[req.byte_addr] = req.writable;
      OpLocalWrite: shadow_bytes[req.byte_addr] = req.data_in;
      OpLocalRead: rsp.local_data = shadow_bytes[req.byte_addr];
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function automatic void check_response(out_item_t got);
    out_item_t want;
    if (pending_responses.size() == 0) begin
      note_mismatch("unexpected response", 0, int'(unsigned'(got)));
      return;
    end
    want = pending_responses.pop_front();
    if (got.tx_valid !== want.tx_valid) begin
      note_mismatch("tx_valid", int'(unsigned'(want.tx_valid)), int'(unsigned'(got.tx_valid)));
    end
    if (got.tx_data !== want.tx_data) begin
      note_mismatch("tx_data", int'(unsigned'(want.tx_data)), int'(unsigned'(got.tx_data)));
    end
    if (got.write_done !== want.write_done) begin
      note_mismatch("write_done", int'(unsigned'(want.write_done)),
                    int'(unsigned'(got.write_done)));
    end
    if (got.local_data !== want.local_data) begin
      note_mismatch("local_data", int'(unsigned'(want.local_data)),
                    int'(unsigned'(got.local_data)));
    end
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IdleSender: return $urandom_range(0, 99) < 78;
      IdleBoth: return $urandom_range(0, 99) < 18;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IdleReceiver: return $urandom_range(0, 99) < 78;
      IdleBoth: return $urandom_range(0, 99) < 18;
      default: return 1'b0;
    endcase
  endfunction

  // Driver: presents queued requests and predicts each one as it is accepted.
  always @(posedge clk_i) begin : drive
    logic next_valid;
    in_item_t next_req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      next_req = in_item_i;
      if (in_valid_i && !in_stall_o) begin
        pending_responses.push_back(predict_register_file_response(in_item_i));
        next_valid = 1'b0;
      end
      if (!next_valid && request_queue.size() != 0 && !sender_idles()) begin
        next_valid = 1'b1;
        next_req = request_queue.pop_front();
      end
      in_valid_i <= next_valid;
      in_item_i <= next_req;
    end
  end

  // Monitor: drives the stall and captures each accepted response.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      response_taken <= 1'b0;
    end else begin
      response_taken <= out_valid_o && !out_stall_i;
      response_item <= out_item_o;
      out_stall_i <= receiver_stalls();
    end
  end

  always @(negedge clk_i) begin
    if (response_taken) check_response(response_item);
  end

  function automatic in_item_t request(logic [2:0] op, logic dir_read, logic [7:0] data_in,
                                       logic [7:0] byte_addr, logic writable);
    in_item_t r;
    r.op = op;
    r.dir_read = dir_read;
    r.data_in = data_in;
    r.byte_addr = byte_addr;
    r.writable = writable;
    return r;
  endfunction

  // Fully random fields with a chosen event code.
  function automatic in_item_t random_request(logic [2:0] op);
    in_item_t r;
    r = in_item_t'(ReqW'($urandom));
    r.op = op;
    return r;
  endfunction

  function automatic void enqueue(in_item_t r);
    request_queue.push_back(r);
    generated_count++;
  endfunction

  // Address or pointer, mostly in range and often near the end of the used bytes.
  function automatic logic [7:0] pick_addr();
    int span;
    int lo;
    int hi;
    span = active_span();
    if (span == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1: return 8'($urandom_range(0, span - 1));
      2: begin
        lo = (span > 3) ? span - 3 : 0;
        hi = (span < 255) ? span + 1 : 255;
        return 8'($urandom_range(lo, hi));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] phase_size(int ph);
    case (ph)
      0: return 9'd256;
      1: return 9'd0;
      2: return 9'd511;
      3: return 9'd37;
      4: return 9'd256;
      default: return 9'd3;
    endcase
  endfunction

  // APB write of the used size, then a read back of the same register.
  task automatic write_used_size(logic [8:0] value);
    logic [CfgDataW-1:0] readback;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= UsedSizeAddr;
    pwdata <= CfgDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow_size = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== CfgDataW'(value)) begin
      note_mismatch("used_size read back", int'(unsigned'(value)), readback);
    end
  endtask

  // Waits until every request is accepted and every response has arrived.
  task automatic wait_drained();
    while (request_queue.size() != 0 || in_valid_i || pending_responses.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Directed sequence, run with eight used bytes.
  task automatic add_directed_requests();
    // Bus events outside their phase and the unused code do nothing.
    enqueue(request(OpTxRequest, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpRxByte, 1'b0, 8'hFF, 8'hFF, 1'b1));
    enqueue(request(OpStop, 1'b1, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpUnused, 1'b1, 8'hFF, 8'hFF, 1'b1));
    // Write map and local port at both ends of the store.
    enqueue(request(OpSetPerm, 1'b0, 8'h00, 8'h00, 1'b1));
    enqueue(request(OpSetPerm, 1'b0, 8'h00, 8'h07, 1'b1));
    enqueue(request(OpSetPerm, 1'b0, 8'h00, 8'hFF, 1'b1));
    enqueue(request(OpLocalWrite, 1'b0, 8'hFF, 8'hFF, 1'b0));
    enqueue(request(OpLocalWrite, 1'b0, 8'hA5, 8'h01, 1'b0));
    enqueue(request(OpLocalRead, 1'b0, 8'h00, 8'hFF, 1'b0));
    enqueue(request(OpLocalRead, 1'b0, 8'h00, 8'h01, 1'b0));
    // Master write: pointer, a stored byte, a refused byte, an ignored match,
    // then a repeated start into a read and a further ignored match.
    enqueue(request(OpAddrMatch, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpRxByte, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpRxByte, 1'b0, 8'h5A, 8'h00, 1'b0));
    enqueue(request(OpRxByte, 1'b0, 8'h11, 8'h00, 1'b0));
    enqueue(request(OpAddrMatch, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpAddrMatch, 1'b1, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpTxRequest, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpAddrMatch, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpStop, 1'b0, 8'h00, 8'h00, 1'b0));
    // Master write running off the end of the used bytes, ended by a stop.
    enqueue(request(OpAddrMatch, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpRxByte, 1'b0, 8'h07, 8'h00, 1'b0));
    enqueue(request(OpRxByte, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpRxByte, 1'b0, 8'hCC, 8'h00, 1'b0));
    enqueue(request(OpStop, 1'b0, 8'h00, 8'h00, 1'b0));
    // Read with the pointer out of range.
    enqueue(request(OpAddrMatch, 1'b1, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpTxRequest, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpStop, 1'b0, 8'h00, 8'h00, 1'b0));
    // Write start without a pointer byte, then a repeated start into a read.
    enqueue(request(OpAddrMatch, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpAddrMatch, 1'b1, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpTxRequest, 1'b0, 8'h00, 8'h00, 1'b0));
    enqueue(request(OpStop, 1'b0, 8'h00, 8'h00, 1'b0));
  endtask

  // One random transfer, burst of local accesses, or a little noise.
  task automatic add_random_transaction();
    in_item_t r;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // Master write, sometimes turning into a read by a repeated start.
      r = random_request(OpAddrMatch);
      r.dir_read = 1'b0;
      enqueue(r);
      if ($urandom_range(0, 9) != 0) begin
        r = random_request(OpRxByte);
        r.data_in = pick_addr();
        enqueue(r);
      end
      repeat ($urandom_range(0, 6)) enqueue(random_request(OpRxByte));
      if ($urandom_range(0, 9) < 3) begin
        r = random_request(OpAddrMatch);
        r.dir_read = 1'b1;
        enqueue(r);
        repeat ($urandom_range(1, 5)) enqueue(random_request(OpTxRequest));
      end
      if ($urandom_range(0, 19) != 0) enqueue(random_request(OpStop));
    end else if (kind < 60) begin
      // Master read from the current pointer.
      r = random_request(OpAddrMatch);
      r.dir_read = 1'b1;
      enqueue(r);
      repeat ($urandom_range(1, 6)) enqueue(random_request(OpTxRequest));
      if ($urandom_range(0, 19) != 0) enqueue(random_request(OpStop));
    end else if (kind < 85) begin
      // Local accesses, mostly to the used bytes.
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0: begin
            r = random_request(OpSetPerm);
            r.writable = ($urandom_range(0, 9) < 7);
          end
          1: r = random_request(OpLocalWrite);
          default: r = random_request(OpLocalRead);
        endcase
        r.byte_addr = pick_addr();
        enqueue(r);
      end
    end else begin
      repeat ($urandom_range(1, 3)) enqueue(in_item_t'(ReqW'($urandom)));
    end
  endtask

  // Main sequence.
  initial begin
    int phase_start;
    for (int i = 0; i < StoreDepth; i++) begin
      shadow_bytes[i] = 8'h00;
      shadow_writable[i] = 1'b0;
    end
    shadow_phase = PhaseIdle;
    shadow_ptr = '0;
    shadow_ptr_valid = 1'b0;
    shadow_size = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_used_size(9'd8);
    add_directed_requests();
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      write_used_size(phase_size(ph));
      phase_start = generated_count;
      while (generated_count - phase_start < RequestsPerPhase) add_random_transaction();
      wait_drained();
    end

    idle_mode = IdleNone;
    repeat (10) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      $display("%0d expected responses never arrived", pending_responses.size());
    end
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
